/* design/ihex_pkg.sv */
// ----------------------------------------------------------------------------
// ihex_pkg
// shared types and constants of the intel hex record encoder
// ----------------------------------------------------------------------------
package ihex_pkg;

  localparam int STORE_DEPTH = 16;                  // bytes per bank
  localparam int IDX_W       = $clog2(STORE_DEPTH); // byte index in a bank
  localparam int LEN_W       = IDX_W + 1;           // byte counts up to STORE_DEPTH
  localparam int MEM_AW      = IDX_W + 1;           // two banks
  localparam int Q_DEPTH     = 2;                   // command queue entries
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  // input item kinds
  localparam logic       REQ_DATA  = 1'b0;
  localparam logic       REQ_END   = 1'b1;

  // record type codes
  localparam logic [7:0] TYPE_DATA = 8'h00;
  localparam logic [7:0] TYPE_EOF  = 8'h01;
  localparam logic [7:0] TYPE_ELA  = 8'h04;

  // one command from the front end: optional ela record, optional data
  // record, optional eof record, emitted in that order
  typedef struct packed {
    logic             ela;
    logic [15:0]      upper;
    logic             has_data;
    logic [15:0]      addr;
    logic [LEN_W-1:0] len;
    logic             bank;
    logic             eof;
  } cmd_t;

  // byte store write from the front end
  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

  // back end has finished reading a bank
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

endpackage

/* design/ihex_if.sv */
// ----------------------------------------------------------------------------
// ihex channel interfaces
// valid/ready channels for input items and record bytes
// ----------------------------------------------------------------------------
interface ihex_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;

  modport source (output valid, req_type, data_byte, input ready);
  modport sink   (input valid, req_type, data_byte, output ready);
endinterface

interface ihex_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] hex_high;
  logic [6:0] hex_low;
  logic       line_start;
  logic       line_end;
  logic       run_last;

  modport source (output valid, hex_high, hex_low, line_start, line_end, run_last,
                  input ready);
  modport sink   (input valid, hex_high, hex_low, line_start, line_end, run_last,
                  output ready);
endinterface

/* design/intel_hex_record_encoder_top.sv */
// ----------------------------------------------------------------------------
// intel_hex_record_encoder_top
// turns a byte image closed by an end item into intel hex (i32hex) records
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      payload
//  in_chan   in   valid/ready    req_type, data_byte
//  out_chan  out  valid/ready    hex_high, hex_low, line_start, line_end, run_last
//  cfg_*     in   cfg_wr_en      cfg_wr_data (start address)
//
//  a record of n bytes leaves as n + 5 record bytes at one byte per cycle while
//  out_chan is ready, plus 7 bytes for an extended linear address record and 5
//  for the eof record; the emitter returns to idle to pick up each command and
//  sets the sustained rate
//  synchronous active-low reset clears the front registers, the queue pointers
//  and the emitter phase and output valid; the byte store holds no reset value and needs no clearing pass
//  a stalled out_chan holds its byte; the front keeps taking bytes into the
//  second store bank while a record drains, and stalls once the command queue
//  is full or the bank it would fill is still being read
//
module intel_hex_record_encoder_top #(
  parameter int RECORD_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  ihex_in_if.sink     in_chan,
  ihex_out_if.source  out_chan,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  // front to queue
  logic                q_push;
  logic                q_full;
  ihex_pkg::cmd_t      push_cmd;

  // queue to back
  logic                q_pop;
  logic                q_valid;
  ihex_pkg::cmd_t      pop_cmd;

  // byte store traffic and bank hand-back
  ihex_pkg::store_wr_t store_wr;
  ihex_pkg::bank_rel_t bank_rel;

  // classifies items, keeps address state, fills the two-bank store
  ihex_front #(
    .RECORD_BYTES (RECORD_BYTES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (push_cmd),
    .store_wr    (store_wr),
    .bank_rel    (bank_rel)
  );

  // decouples the front from the emitter
  ihex_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_cmd   (pop_cmd)
  );

  // walks each command byte by byte, building header and checksum
  ihex_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .store_wr (store_wr),
    .q_valid  (q_valid),
    .q_cmd    (pop_cmd),
    .q_pop    (q_pop),
    .bank_rel (bank_rel),
    .out_chan (out_chan)
  );

endmodule

/* design/ihex_front.sv */
// ----------------------------------------------------------------------------
// ihex_front
// takes input items, fills the byte store and issues record commands
// ----------------------------------------------------------------------------
module ihex_front #(
  parameter int RECORD_BYTES = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  ihex_in_if.sink                 in_chan,
  input  logic                    cfg_wr_en,
  input  logic [31:0]             cfg_wr_data,
  input  logic                    q_full,
  output logic                    q_push,
  output ihex_pkg::cmd_t          q_cmd,
  output ihex_pkg::store_wr_t     store_wr,
  input  ihex_pkg::bank_rel_t     bank_rel
);

  localparam int REC_LEN = (RECORD_BYTES < 1) ? 1 :
                           (RECORD_BYTES > ihex_pkg::STORE_DEPTH) ? ihex_pkg::STORE_DEPTH :
                           RECORD_BYTES;

  logic [31:0]                start_r, start_nxt;
  logic [31:0]                rec_addr_r, rec_addr_nxt;
  logic [ihex_pkg::LEN_W-1:0] fill_r, fill_nxt;
  logic [15:0]                sent_r, sent_nxt;
  logic                       bank_r, bank_nxt;
  logic [1:0]                 busy_r, busy_nxt;

  logic                       accept;
  logic                       is_data;
  logic [ihex_pkg::LEN_W-1:0] fill_new;
  logic [31:0]                next_addr;
  logic                       close_data;
  logic                       has_data;
  logic [15:0]                upper;

  assign in_chan.ready = !q_full && !busy_r[bank_r];
  assign accept        = in_chan.valid && in_chan.ready;
  assign is_data       = (in_chan.req_type == ihex_pkg::REQ_DATA);
  assign fill_new      = fill_r + ihex_pkg::LEN_W'(1);
  assign next_addr     = rec_addr_r + 32'(fill_new);
  assign upper         = rec_addr_r[31:16];

  // record closes when full or when the next byte opens a new segment
  assign close_data = is_data &&
                      ((fill_new >= ihex_pkg::LEN_W'(REC_LEN)) || (next_addr[15:0] == 16'h0));
  assign has_data   = close_data || (!is_data && (fill_r != '0));

  assign q_push         = accept && (has_data || !is_data);
  assign q_cmd.ela      = has_data && (upper != sent_r);
  assign q_cmd.upper    = upper;
  assign q_cmd.has_data = has_data;
  assign q_cmd.addr     = rec_addr_r[15:0];
  assign q_cmd.len      = is_data ? fill_new : fill_r;
  assign q_cmd.bank     = bank_r;
  assign q_cmd.eof      = !is_data;

  assign store_wr.en   = accept && is_data;
  assign store_wr.addr = {bank_r, fill_r[ihex_pkg::IDX_W-1:0]};
  assign store_wr.data = in_chan.data_byte;

  always_comb begin
    start_nxt    = start_r;
    rec_addr_nxt = rec_addr_r;
    fill_nxt     = fill_r;
    sent_nxt     = sent_r;
    bank_nxt     = bank_r;
    busy_nxt     = busy_r;
    if (bank_rel.valid) begin
      busy_nxt[bank_rel.bank] = 1'b0;
    end
    if (cfg_wr_en) begin
      start_nxt    = cfg_wr_data;
      rec_addr_nxt = cfg_wr_data;
      fill_nxt     = '0;
    end else if (accept) begin
      if (has_data) begin
        bank_nxt         = !bank_r;
        busy_nxt[bank_r] = 1'b1;
      end
      if (!is_data) begin
        fill_nxt     = '0;
        rec_addr_nxt = start_r;
        sent_nxt     = '0;
      end else if (close_data) begin
        fill_nxt     = '0;
        rec_addr_nxt = next_addr;
        sent_nxt     = upper;
      end else begin
        fill_nxt = fill_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r    <= '0;
      rec_addr_r <= '0;
      fill_r     <= '0;
      sent_r     <= '0;
      bank_r     <= 1'b0;
      busy_r     <= '0;
    end else begin
      start_r    <= start_nxt;
      rec_addr_r <= rec_addr_nxt;
      fill_r     <= fill_nxt;
      sent_r     <= sent_nxt;
      bank_r     <= bank_nxt;
      busy_r     <= busy_nxt;
    end
  end

endmodule

/* design/ihex_cmd_queue.sv */
// ----------------------------------------------------------------------------
// ihex_cmd_queue
// short fifo of record commands between front and back end
// ----------------------------------------------------------------------------
module ihex_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ihex_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output ihex_pkg::cmd_t pop_cmd
);

  ihex_pkg::cmd_t               slot_r [ihex_pkg::Q_DEPTH];
  logic [ihex_pkg::Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [ihex_pkg::Q_CNT_W-1:0] cnt_r;
  logic                         do_push, do_pop;

  assign full      = (cnt_r == ihex_pkg::Q_CNT_W'(ihex_pkg::Q_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_cmd   = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == ihex_pkg::Q_PTR_W'(ihex_pkg::Q_DEPTH - 1)) ?
                    '0 : wr_ptr_r + ihex_pkg::Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == ihex_pkg::Q_PTR_W'(ihex_pkg::Q_DEPTH - 1)) ?
                    '0 : rd_ptr_r + ihex_pkg::Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + ihex_pkg::Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - ihex_pkg::Q_CNT_W'(1);
      end
    end
  end

endmodule

/* design/ihex_back.sv */
// ----------------------------------------------------------------------------
// ihex_back
// byte store and record emitter, one record byte per cycle while out_chan is ready
// ----------------------------------------------------------------------------
module ihex_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ihex_pkg::store_wr_t store_wr,
  input  logic                q_valid,
  input  ihex_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output ihex_pkg::bank_rel_t bank_rel,
  ihex_out_if.source          out_chan
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ELA  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_EOF  = 2'd3;

  localparam int HDR_BYTES = 4;

  function automatic logic [6:0] hex_digit(input logic [3:0] nib);
    hex_digit = (nib < 4'd10) ? (7'h30 + {3'b000, nib}) : (7'h37 + {3'b000, nib});
  endfunction

  logic [7:0] mem [2 * ihex_pkg::STORE_DEPTH];

  logic [1:0]                 phase_r, phase_nxt;
  logic [ihex_pkg::LEN_W-1:0] pos_r, pos_nxt;
  logic [7:0]                 sum_r, sum_nxt;
  ihex_pkg::cmd_t             cmd_r, cmd_nxt;
  logic [7:0]                 rd_data_r;
  logic                       out_valid_r, out_valid_nxt;
  logic [6:0]                 hex_high_r, hex_low_r;
  logic                       line_start_r, line_end_r, run_last_r;

  logic [ihex_pkg::LEN_W-1:0] rec_len;
  logic [15:0]                rec_addr;
  logic [7:0]                 rec_type;
  logic [7:0]                 cur_byte;
  logic                       end_of_rec;
  logic                       last_of_cmd;
  logic                       emit;
  logic [1:0]                 after_rec;
  logic [1:0]                 first_phase;
  logic [ihex_pkg::LEN_W-1:0] rd_idx;

  // per-record header fields
  always_comb begin
    case (phase_r)
      PH_ELA: begin
        rec_len  = ihex_pkg::LEN_W'(2);
        rec_addr = 16'h0;
        rec_type = ihex_pkg::TYPE_ELA;
      end
      PH_DATA: begin
        rec_len  = cmd_r.len;
        rec_addr = cmd_r.addr;
        rec_type = ihex_pkg::TYPE_DATA;
      end
      default: begin
        rec_len  = '0;
        rec_addr = 16'h0;
        rec_type = ihex_pkg::TYPE_EOF;
      end
    endcase
  end

  assign end_of_rec = (pos_r == rec_len + ihex_pkg::LEN_W'(HDR_BYTES));

  always_comb begin
    case (pos_r)
      ihex_pkg::LEN_W'(0): cur_byte = {{(8 - ihex_pkg::LEN_W){1'b0}}, rec_len};
      ihex_pkg::LEN_W'(1): cur_byte = rec_addr[15:8];
      ihex_pkg::LEN_W'(2): cur_byte = rec_addr[7:0];
      ihex_pkg::LEN_W'(3): cur_byte = rec_type;
      default: begin
        if (end_of_rec) begin
          cur_byte = 8'h00 - sum_r;
        end else if (phase_r == PH_ELA) begin
          cur_byte = (pos_r == ihex_pkg::LEN_W'(HDR_BYTES)) ? cmd_r.upper[15:8] :
                                                               cmd_r.upper[7:0];
        end else begin
          cur_byte = rd_data_r;
        end
      end
    endcase
  end

  always_comb begin
    case (phase_r)
      PH_ELA:  after_rec = cmd_r.has_data ? PH_DATA : (cmd_r.eof ? PH_EOF : PH_IDLE);
      PH_DATA: after_rec = cmd_r.eof ? PH_EOF : PH_IDLE;
      default: after_rec = PH_IDLE;
    endcase
  end

  assign first_phase = q_cmd.ela ? PH_ELA : (q_cmd.has_data ? PH_DATA : PH_EOF);
  assign last_of_cmd = end_of_rec && (after_rec == PH_IDLE);
  assign emit        = (phase_r != PH_IDLE) && (!out_valid_r || out_chan.ready);
  assign q_pop       = (phase_r == PH_IDLE) && q_valid;

  assign bank_rel.valid = emit && (phase_r == PH_DATA) && end_of_rec;
  assign bank_rel.bank  = cmd_r.bank;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    cmd_nxt   = cmd_r;
    if (q_pop) begin
      cmd_nxt   = q_cmd;
      phase_nxt = first_phase;
      pos_nxt   = '0;
      sum_nxt   = 8'h00;
    end else if (emit) begin
      if (end_of_rec) begin
        phase_nxt = after_rec;
        pos_nxt   = '0;
        sum_nxt   = 8'h00;
      end else begin
        pos_nxt = pos_r + ihex_pkg::LEN_W'(1);
        sum_nxt = sum_r + cur_byte;
      end
    end
    out_valid_nxt = emit ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);
  end

  // read one step ahead so the payload byte is ready with the state
  assign rd_idx = pos_nxt - ihex_pkg::LEN_W'(HDR_BYTES);

  always_ff @(posedge clk) begin
    if (store_wr.en) begin
      mem[store_wr.addr] <= store_wr.data;
    end
    rd_data_r <= mem[{cmd_nxt.bank, rd_idx[ihex_pkg::IDX_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      hex_high_r   <= hex_digit(cur_byte[7:4]);
      hex_low_r    <= hex_digit(cur_byte[3:0]);
      line_start_r <= (pos_r == '0);
      line_end_r   <= end_of_rec;
      run_last_r   <= last_of_cmd;
    end
    cmd_r <= cmd_nxt;
    pos_r <= pos_nxt;
    sum_r <= sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.hex_high   = hex_high_r;
  assign out_chan.hex_low    = hex_low_r;
  assign out_chan.line_start = line_start_r;
  assign out_chan.line_end   = line_end_r;
  assign out_chan.run_last   = run_last_r;

endmodule
